>>> hw/rtl/ptmi_pkg.sv
// shared types, constants and microcode program for the page table map insert block
package ptmi_pkg;

    // field widths
    localparam int VPAGE_W    = 36;
    localparam int FRAME_W    = 40;
    localparam int BASE_W     = 40;
    localparam int STATUS_W   = 2;
    localparam int ADDED_W    = 2;
    localparam int ENTRY_W    = 64;
    localparam int IDX_W      = 9;
    localparam int APB_AW     = 3;
    localparam int APB_DW     = 64;

    localparam int TABLE_PAGES_DEF = 64;

    // register map
    localparam logic [APB_AW-1:0] ADDR_TABLE_FRAME_BASE = 3'd0;

    // result codes
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OUTSIDE = 2'd2;

    // entry flags
    localparam logic [11:0] TABLE_FLAGS = 12'h007;

    typedef logic [3:0] t_step;

    localparam t_step S_CLEAR = 4'd0;
    localparam t_step S_IDLE  = 4'd1;
    localparam t_step S_READ  = 4'd2;
    localparam t_step S_EVAL  = 4'd3;
    localparam t_step S_CHECK = 4'd4;
    localparam t_step S_NEXT  = 4'd5;
    localparam t_step S_GATE  = 4'd6;
    localparam t_step S_LEAF  = 4'd7;
    localparam t_step S_DONE  = 4'd8;

    typedef enum logic [3:0] {
        OP_NOP    = 4'd0,
        OP_CLEAR  = 4'd1,
        OP_ACCEPT = 4'd2,
        OP_READ   = 4'd3,
        OP_EVAL   = 4'd4,
        OP_CHECK  = 4'd5,
        OP_NEXT   = 4'd6,
        OP_LEAF   = 4'd7,
        OP_DONE   = 4'd8
    } t_op;

    typedef enum logic [2:0] {
        C_ALWAYS   = 3'd0,
        C_CLR_MORE = 3'd1,
        C_NO_BEAT  = 3'd2,
        C_ABSENT   = 3'd3,
        C_MORE     = 3'd4,
        C_FAIL     = 3'd5,
        C_OUT_BUSY = 3'd6
    } t_cond;

    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_step tgt_true;
        t_step tgt_false;
    } t_ucode;

    // datapath conditions seen by the sequencer
    typedef struct packed {
        logic clr_more;
        logic in_beat;
        logic absent;
        logic more;
        logic fail;
        logic out_busy;
    } t_flags;

    function automatic t_ucode ucode_rom(input t_step step);
        t_ucode cw;
        case (step)
            S_CLEAR: cw = '{OP_CLEAR,  C_CLR_MORE, S_CLEAR, S_IDLE};
            S_IDLE:  cw = '{OP_ACCEPT, C_NO_BEAT,  S_IDLE,  S_READ};
            S_READ:  cw = '{OP_READ,   C_ALWAYS,   S_EVAL,  S_EVAL};
            S_EVAL:  cw = '{OP_EVAL,   C_ABSENT,   S_NEXT,  S_CHECK};
            S_CHECK: cw = '{OP_CHECK,  C_ALWAYS,   S_NEXT,  S_NEXT};
            S_NEXT:  cw = '{OP_NEXT,   C_MORE,     S_READ,  S_GATE};
            S_GATE:  cw = '{OP_NOP,    C_FAIL,     S_DONE,  S_LEAF};
            S_LEAF:  cw = '{OP_LEAF,   C_ALWAYS,   S_DONE,  S_DONE};
            S_DONE:  cw = '{OP_DONE,   C_OUT_BUSY, S_DONE,  S_IDLE};
            default: cw = '{OP_NOP,    C_ALWAYS,   S_IDLE,  S_IDLE};
        endcase
        return cw;
    endfunction

endpackage

>>> hw/rtl/ptmi_if.sv
// request and response channel interfaces
interface ptmi_req_if;
    logic                          valid;
    logic                          ready;
    logic [ptmi_pkg::VPAGE_W-1:0]  virt_page;
    logic [ptmi_pkg::FRAME_W-1:0]  phys_frame;
    logic                          user_access;

    modport source (output valid, output virt_page, output phys_frame,
                    output user_access, input ready);
    modport sink   (input valid, input virt_page, input phys_frame,
                    input user_access, output ready);
endinterface

interface ptmi_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [ptmi_pkg::STATUS_W-1:0] status;
    logic [ptmi_pkg::ADDED_W-1:0]  tables_added;
    logic [ptmi_pkg::ENTRY_W-1:0]  leaf_entry;

    modport source (output valid, output status, output tables_added,
                    output leaf_entry, input ready);
    modport sink   (input valid, input status, input tables_added,
                    input leaf_entry, output ready);
endinterface

>>> hw/rtl/page_table_map_insert_top.sv
// top level: four-level page table map insert with local table store
// After reset the table store (TABLE_PAGES*512 entries of 64 bits) is swept to
// zero one entry a cycle, so no request is taken until the sweep has reached
// the last entry; configuration writes are taken throughout. Each request then
// walks the three upper levels and writes the leaf, under a small microcode
// program over a single-port store: one access a step, every level read,
// checked and followed before the next can start. A level followed through a
// present entry adds a check step to its read and evaluate steps, and a request
// that fails stops its walk early and skips the leaf write. The result sits in
// an output register, so the next request is taken while the last result still
// waits.
module page_table_map_insert_top #(
    parameter int TABLE_PAGES = ptmi_pkg::TABLE_PAGES_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // configuration port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ptmi_pkg::APB_AW-1:0]  paddr,
    input  logic [ptmi_pkg::APB_DW-1:0]  pwdata,
    output logic [ptmi_pkg::APB_DW-1:0]  prdata,
    output logic                         pready,
    // channels
    ptmi_req_if.sink                     i_req,
    ptmi_rsp_if.source                   o_rsp
);
    import ptmi_pkg::*;

    // page number and fill counter widths follow from the store size
    localparam int PAGE_W = $clog2(TABLE_PAGES);
    localparam int CNT_W  = $clog2(TABLE_PAGES + 1);
    localparam int ADDR_W = PAGE_W + IDX_W;
    localparam int DEPTH  = TABLE_PAGES * (1 << IDX_W);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0]  PAGES_CNT = CNT_W'(TABLE_PAGES);

    // control word and conditions
    t_ucode cw;
    t_flags flags;

    // table store
    logic [ENTRY_W-1:0] r_store [DEPTH];
    logic [ENTRY_W-1:0] r_rdata;
    logic               we;
    logic [ADDR_W-1:0]  waddr;
    logic [ENTRY_W-1:0] wdata;
    logic [ADDR_W-1:0]  raddr;

    // request held for the walk
    logic [VPAGE_W-1:0] r_vpage;
    logic [FRAME_W-1:0] r_frame;
    logic               r_user;

    // walk state
    logic [1:0]          r_lvl;
    logic [PAGE_W-1:0]   r_page;
    logic [CNT_W-1:0]    r_nf;
    logic [ADDED_W-1:0]  r_added;
    logic [STATUS_W-1:0] r_status;
    logic [ENTRY_W-1:0]  r_diff;
    logic [ENTRY_W-1:0]  r_leaf;
    logic [ADDR_W-1:0]   r_clr_addr;
    logic [BASE_W-1:0]   r_base;

    // output register
    logic                r_out_valid;
    logic [STATUS_W-1:0] r_out_status;
    logic [ADDED_W-1:0]  r_out_added;
    logic [ENTRY_W-1:0]  r_out_leaf;

    logic [IDX_W-1:0]   idx_cur;
    logic [IDX_W-1:0]   idx_leaf;
    logic               full;
    logic               in_range;
    logic [BASE_W:0]    new_frame;
    logic [ENTRY_W-1:0] new_entry;
    logic [ENTRY_W-1:0] leaf_val;
    logic               cfg_wr;

    ptmi_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (flags),
        .o_cw    (cw)
    );

    // configuration port, no wait states
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr == ADDR_TABLE_FRAME_BASE) ?
                    {{(APB_DW-BASE_W){1'b0}}, r_base} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= '0;
        end else if (cfg_wr && paddr == ADDR_TABLE_FRAME_BASE) begin
            r_base <= pwdata[BASE_W-1:0];
        end
    end

    // 9-bit index of the level being walked, top level first
    always_comb begin
        case (r_lvl)
            2'd0:    idx_cur = r_vpage[4*IDX_W-1:3*IDX_W];
            2'd1:    idx_cur = r_vpage[3*IDX_W-1:2*IDX_W];
            2'd2:    idx_cur = r_vpage[2*IDX_W-1:IDX_W];
            default: idx_cur = r_vpage[IDX_W-1:0];
        endcase
    end
    assign idx_leaf = r_vpage[IDX_W-1:0];

    // new table entry points at the frame of the page being handed out
    assign full      = (r_nf >= PAGES_CNT);
    assign new_frame = (BASE_W+1)'(r_base) + (BASE_W+1)'(r_nf);
    assign new_entry = {{(ENTRY_W-BASE_W-13){1'b0}}, new_frame, TABLE_FLAGS};
    // leaf: present and writable always, user on request
    assign leaf_val  = {{(ENTRY_W-FRAME_W-12){1'b0}}, r_frame, 9'd0, r_user, 2'b11};

    // a present entry is good only if it names a page already handed out
    assign in_range = (r_diff[ENTRY_W-1:CNT_W] == '0) && (r_diff[CNT_W-1:0] < r_nf);

    assign raddr = {r_page, idx_cur};

    always_comb begin
        we    = 1'b0;
        waddr = raddr;
        wdata = new_entry;
        unique case (cw.op)
            OP_CLEAR: begin
                we    = 1'b1;
                waddr = r_clr_addr;
                wdata = '0;
            end
            OP_EVAL: begin
                we = !r_rdata[0] && !full;
            end
            OP_LEAF: begin
                we    = 1'b1;
                waddr = {r_page, idx_leaf};
                wdata = leaf_val;
            end
            default: begin
                we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_store[waddr] <= wdata;
        end
        if (cw.op == OP_READ) begin
            r_rdata <= r_store[raddr];
        end
    end

    // conditions for the sequencer
    assign flags.clr_more = (r_clr_addr != LAST_ADDR);
    assign flags.in_beat  = i_req.valid && i_req.ready;
    assign flags.absent   = !r_rdata[0];
    assign flags.more     = (r_lvl != 2'd2) && (r_status == ST_OK);
    assign flags.fail     = (r_status != ST_OK);
    assign flags.out_busy = r_out_valid && !o_rsp.ready;

    assign i_req.ready = (cw.op == OP_ACCEPT);

    // request payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (flags.in_beat) begin
            r_vpage <= i_req.virt_page;
            r_frame <= i_req.phys_frame;
            r_user  <= i_req.user_access;
        end
        if (cw.op == OP_EVAL) begin
            r_diff <= {12'd0, r_rdata[ENTRY_W-1:12]} -
                      {{(ENTRY_W-BASE_W){1'b0}}, r_base};
        end
    end

    // walk control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lvl      <= '0;
            r_page     <= '0;
            r_nf       <= CNT_W'(1);
            r_added    <= '0;
            r_status   <= ST_OK;
            r_leaf     <= '0;
            r_clr_addr <= '0;
        end else begin
            case (cw.op)
                OP_CLEAR: begin
                    if (flags.clr_more) begin
                        r_clr_addr <= r_clr_addr + 1'b1;
                    end
                end
                OP_ACCEPT: begin
                    if (flags.in_beat) begin
                        r_lvl    <= '0;
                        r_page   <= '0;
                        r_added  <= '0;
                        r_status <= ST_OK;
                        r_leaf   <= '0;
                    end
                end
                OP_EVAL: begin
                    if (!r_rdata[0]) begin
                        if (full) begin
                            r_status <= ST_FULL;
                        end else begin
                            // take the next free page for this level
                            r_page  <= r_nf[PAGE_W-1:0];
                            r_nf    <= r_nf + 1'b1;
                            r_added <= r_added + 1'b1;
                        end
                    end
                end
                OP_CHECK: begin
                    if (in_range) begin
                        r_page <= r_diff[PAGE_W-1:0];
                    end else begin
                        r_status <= ST_OUTSIDE;
                    end
                end
                OP_NEXT: begin
                    r_lvl <= r_lvl + 1'b1;
                end
                OP_LEAF: begin
                    r_leaf <= leaf_val;
                end
                default: begin
                    r_lvl <= r_lvl;
                end
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (cw.op == OP_DONE && !flags.out_busy) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (cw.op == OP_DONE && !flags.out_busy) begin
            r_out_status <= r_status;
            r_out_added  <= r_added;
            r_out_leaf   <= r_leaf;
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.status       = r_out_status;
    assign o_rsp.tables_added = r_out_added;
    assign o_rsp.leaf_entry   = r_out_leaf;

    // no request is taken before the clearing sweep has reached the last entry
    a_no_beat_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.ready |-> (r_clr_addr == LAST_ADDR))
        else $error("request taken before store clear finished");

    // every new table bumps the free page counter by one
    a_alloc_bumps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cw.op == OP_EVAL && !r_rdata[0] && !full) |=> (r_nf == $past(r_nf) + 1'b1))
        else $error("free page counter out of step with allocation");

    // the counter never hands out more pages than the store holds
    a_nf_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cw.op == OP_EVAL) |=> (r_nf <= PAGES_CNT))
        else $error("free page counter beyond store");

    // a result beat carries a leaf only on success
    a_leaf_matches_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((r_out_status == ST_OK) ? r_out_leaf[0] : (r_out_leaf == '0)))
        else $error("leaf entry disagrees with status");

endmodule

>>> hw/rtl/ptmi_seq.sv
// microcode sequencer: step counter, control store and conditional jumps
module ptmi_seq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  ptmi_pkg::t_flags i_flags,
    output ptmi_pkg::t_ucode o_cw
);
    import ptmi_pkg::*;

    t_step  r_step;
    t_step  n_step;
    t_ucode cw;
    logic   take;

    assign cw   = ucode_rom(r_step);
    assign o_cw = cw;

    always_comb begin
        unique case (cw.cond)
            C_ALWAYS:   take = 1'b1;
            C_CLR_MORE: take = i_flags.clr_more;
            C_NO_BEAT:  take = !i_flags.in_beat;
            C_ABSENT:   take = i_flags.absent;
            C_MORE:     take = i_flags.more;
            C_FAIL:     take = i_flags.fail;
            C_OUT_BUSY: take = i_flags.out_busy;
            default:    take = 1'b1;
        endcase
        n_step = take ? cw.tgt_true : cw.tgt_false;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= S_CLEAR;
        end else begin
            r_step <= n_step;
        end
    end

endmodule
